FILE: rtl/stt_pkg.sv
// Shared types, constants and the sine table builder for the test tone generator.
// No dependencies; every module of the block imports this package.
package stt_pkg;

   localparam int unsigned FRAME_RATE_DEF   = 16000;
   localparam int unsigned SINE_ENTRIES_DEF = 1024;

   localparam int unsigned FIELD_W  = 16;
   localparam int unsigned VOL_W    = 7;
   localparam int unsigned AMP_W    = 14;
   localparam int unsigned SAMPLE_W = 15;
   localparam int unsigned PHASE_W  = 32;
   localparam int unsigned FRAMES_W = 20;
   localparam int unsigned PROD_W   = 20;

   localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
   localparam logic [VOL_W-1:0] VOL_RESET = 7'd100;

   // configuration register indexes
   localparam logic CSR_VOLUME = 1'b0;
   localparam logic CSR_ENABLE = 1'b1;

   // item opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [63:0] PI_Q31 = 64'd6746518852;
   localparam logic [63:0] TONE_AMPLITUDE = 64'd10000;
   localparam logic [63:0] TONE_HALF      = TONE_AMPLITUDE / 64'd2;

   // frames = x / 1000 by reciprocal, exact for x below the saturation limit
   localparam logic [31:0]  FRAME_LIMIT = 32'd1048576000;
   localparam logic [30:0]  FRAME_RECIP = 31'd1099511628;
   localparam int unsigned  FRAME_SHIFT = 40;

   // p / 100 by reciprocal, exact for p below 2^20
   localparam logic [20:0]  PCT_RECIP = 21'd1342178;
   localparam int unsigned  PCT_SHIFT = 27;

   // Taylor term divisors (2k)(2k+1) by reciprocal, ceil(2^48 / divisor), k = 19 down to 1;
   // exact for dividends below 2^34
   localparam int unsigned TAYLOR_SHIFT = 48;
   localparam logic [63:0] TAYLOR_ONE   = 64'd1 << TAYLOR_SHIFT;
   localparam logic [19:1][63:0] TAYLOR_RECIP = {
      TAYLOR_ONE / 64'd1482 + 64'd1, TAYLOR_ONE / 64'd1332 + 64'd1,
      TAYLOR_ONE / 64'd1190 + 64'd1, TAYLOR_ONE / 64'd1056 + 64'd1,
      TAYLOR_ONE / 64'd930 + 64'd1,  TAYLOR_ONE / 64'd812 + 64'd1,
      TAYLOR_ONE / 64'd702 + 64'd1,  TAYLOR_ONE / 64'd600 + 64'd1,
      TAYLOR_ONE / 64'd506 + 64'd1,  TAYLOR_ONE / 64'd420 + 64'd1,
      TAYLOR_ONE / 64'd342 + 64'd1,  TAYLOR_ONE / 64'd272 + 64'd1,
      TAYLOR_ONE / 64'd210 + 64'd1,  TAYLOR_ONE / 64'd156 + 64'd1,
      TAYLOR_ONE / 64'd110 + 64'd1,  TAYLOR_ONE / 64'd72 + 64'd1,
      TAYLOR_ONE / 64'd42 + 64'd1,   TAYLOR_ONE / 64'd20 + 64'd1,
      TAYLOR_ONE / 64'd6 + 64'd1
   };

   typedef struct packed {
      logic                valid;
      logic                tick;
      logic                load;
      logic [PHASE_W-1:0]  inc;
      logic [FRAMES_W-1:0] frames;
   } setup_type;

   typedef struct packed {
      logic valid;
      logic active;
      logic last_frame;
      logic neg;
   } ctrl_type;

   // floor(10000 * sin(num/den * pi/2)) in Q31, Taylor series; elaboration only.
   // den is a power of two.
   function automatic logic [AMP_W-1:0] quarter_sine(input logic [63:0] num,
                                                     input logic [63:0] den);
      logic [63:0]        theta;
      logic [63:0]        term;
      logic [63:0]        t2;
      logic [63:0]        k;
      logic [63:0]        res;
      logic [127:0]       quot_wide;
      logic signed [63:0] sum;
      if (num == 64'd0) begin
         return '0;
      end
      if (num >= den) begin
         return AMP_W'(TONE_AMPLITUDE);
      end
      if (64'd3 * num == den) begin
         return AMP_W'(TONE_HALF);
      end
      theta = (num * PI_Q31) >> ($clog2(den) + 1);
      t2    = (theta * theta) >> 31;
      term  = theta;
      sum   = signed'(theta);
      for (k = 64'd1; k < 64'd20 && term != 64'd0; k++) begin
         quot_wide = 128'((term * t2) >> 31) * 128'(TAYLOR_RECIP[k[4:0]]);
         term      = quot_wide[TAYLOR_SHIFT +: 64];
         if (k[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      res = (unsigned'(sum) * TONE_AMPLITUDE) >> 31;
      return res[AMP_W-1:0];
   endfunction

endpackage

FILE: rtl/stt_setup.sv
// Start-item arithmetic: phase step and frame count, two pipeline stages.
// Depends on stt_pkg.
module stt_setup import stt_pkg::*; #(
   parameter int unsigned FRAME_RATE = FRAME_RATE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic               in_opcode,
   input  logic [FIELD_W-1:0] in_freq,
   input  logic [FIELD_W-1:0] in_dur,
   input  logic               output_enable,
   output setup_type          s2_ff
);

   // ceil(2^64 / rate): step = (freq * recip)[63:32]
   localparam logic [63:0] INC_RECIP = 64'hFFFF_FFFF_FFFF_FFFF / 64'(FRAME_RATE) + 64'd1;
   localparam int unsigned SPLIT     = 26;
   localparam int unsigned HALF_W    = FIELD_W + SPLIT;
   localparam logic [SPLIT-1:0] RECIP_HI = INC_RECIP[2*SPLIT-1:SPLIT];
   localparam logic [SPLIT-1:0] RECIP_LO = INC_RECIP[SPLIT-1:0];
   localparam logic [FIELD_W-1:0] RATE   = FIELD_W'(FRAME_RATE);

   logic              s1_valid_ff, s1_tick_ff, s1_load_ff;
   logic [31:0]       s1_rate_prod_ff, s1_rate_prod_in;
   logic [HALF_W-1:0] s1_hi_ff, s1_hi_in, s1_lo_ff, s1_lo_in;
   logic              s1_load_in;
   logic [HALF_W+SPLIT-1:0] inc_sum;
   logic [60:0]       frame_prod;
   setup_type         s2_in;

   assign s1_load_in = (in_opcode == OP_START) && output_enable &&
                       (in_freq != '0) && (in_dur != '0);
   assign s1_rate_prod_in = 32'(in_dur) * 32'(RATE);
   assign s1_hi_in = HALF_W'(in_freq) * HALF_W'(RECIP_HI);
   assign s1_lo_in = HALF_W'(in_freq) * HALF_W'(RECIP_LO);

   assign inc_sum    = {s1_hi_ff, SPLIT'(0)} + (HALF_W+SPLIT)'(s1_lo_ff);
   assign frame_prod = 61'(s1_rate_prod_ff[29:0]) * 61'(FRAME_RECIP);

   always_comb begin
      s2_in.valid = s1_valid_ff;
      s2_in.tick  = s1_tick_ff;
      s2_in.load  = s1_load_ff;
      s2_in.inc   = inc_sum[63:32];
      if (s1_rate_prod_ff >= FRAME_LIMIT) begin
         s2_in.frames = '1;
      end else begin
         s2_in.frames = frame_prod[FRAME_SHIFT+FRAMES_W-1:FRAME_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_tick_ff  <= 1'b0;
         s1_load_ff  <= 1'b0;
         s2_ff       <= '0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s1_tick_ff  <= (in_opcode == OP_TICK);
         s1_load_ff  <= in_valid && s1_load_in;
         s2_ff       <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rate_prod_ff <= s1_rate_prod_in;
         s1_hi_ff        <= s1_hi_in;
         s1_lo_ff        <= s1_lo_in;
      end
   end

endmodule

FILE: rtl/stt_phase.sv
// Tone state (phase accumulator, phase step, frames left) and table address.
// Depends on stt_pkg.
module stt_phase import stt_pkg::*; #(
   parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF,
   parameter int unsigned ADDR_W       = $clog2(SINE_ENTRIES / 4 + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  setup_type         s2,
   output ctrl_type          s3_ctrl_ff,
   output logic [ADDR_W-1:0] s3_addr_ff
);

   localparam int unsigned IDX_W   = $clog2(SINE_ENTRIES);
   localparam int unsigned J_W     = IDX_W - 2;
   localparam int unsigned QUARTER = SINE_ENTRIES / 4;

   logic [PHASE_W-1:0]  phase_ff, inc_ff;
   logic [FRAMES_W-1:0] frames_ff;
   logic [J_W-1:0]      quarter_idx;
   logic [ADDR_W-1:0]   s3_addr_in;
   ctrl_type            s3_ctrl_in;

   // top bits of the phase: quadrant, then position inside the quadrant
   assign quarter_idx = phase_ff[PHASE_W-3 -: J_W];

   always_comb begin
      if (phase_ff[PHASE_W-2]) begin
         s3_addr_in = ADDR_W'(QUARTER) - ADDR_W'(quarter_idx);
      end else begin
         s3_addr_in = ADDR_W'(quarter_idx);
      end
      s3_ctrl_in.valid      = s2.valid && s2.tick;
      s3_ctrl_in.active     = (frames_ff != '0);
      s3_ctrl_in.last_frame = (frames_ff == FRAMES_W'(1));
      s3_ctrl_in.neg        = phase_ff[PHASE_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         inc_ff     <= '0;
         frames_ff  <= '0;
         s3_ctrl_ff <= '0;
      end else if (advance) begin
         s3_ctrl_ff <= s3_ctrl_in;
         if (s2.valid && s2.load) begin
            phase_ff  <= '0;
            inc_ff    <= s2.inc;
            frames_ff <= s2.frames;
         end else if (s2.valid && s2.tick && (frames_ff != '0)) begin
            phase_ff  <= phase_ff + inc_ff;
            frames_ff <= frames_ff - FRAMES_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_addr_ff <= s3_addr_in;
      end
   end

endmodule

FILE: rtl/stt_sine_rom.sv
// Quarter-wave sine magnitude ROM with registered read, built at elaboration.
// Depends on stt_pkg.
module stt_sine_rom import stt_pkg::*; #(
   parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF,
   parameter int unsigned ADDR_W       = $clog2(SINE_ENTRIES / 4 + 1)
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [ADDR_W-1:0] addr,
   output logic [AMP_W-1:0]  rd_data_ff
);

   localparam int unsigned QUARTER = SINE_ENTRIES / 4;

   logic [AMP_W-1:0] rom_table [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
      localparam logic [AMP_W-1:0] ENTRY = quarter_sine(64'(4 * g), 64'(SINE_ENTRIES));
      assign rom_table[g] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_data_ff <= rom_table[addr];
      end
   end

endmodule

FILE: rtl/stt_scale.sv
// Volume scaling (multiply, then divide by 100 by reciprocal) and result register.
// Depends on stt_pkg.
module stt_scale import stt_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ctrl_type                   s3_ctrl,
   input  logic [AMP_W-1:0]           mag,
   input  logic [VOL_W-1:0]           volume,
   output logic                       out_valid_ff,
   output logic signed [SAMPLE_W-1:0] out_sample_ff,
   output logic                       out_active_ff,
   output logic                       out_last_ff
);

   ctrl_type                    c4_ff, c5_ff;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [40:0]                 quot_full;
   logic [AMP_W-1:0]            quot;
   logic signed [SAMPLE_W-1:0]  pos;
   logic signed [SAMPLE_W-1:0]  out_sample_in;

   assign prod_in   = PROD_W'((AMP_W+VOL_W)'(mag) * (AMP_W+VOL_W)'(volume));
   assign quot_full = 41'(prod_ff) * 41'(PCT_RECIP);
   assign quot      = quot_full[PCT_SHIFT+AMP_W-1:PCT_SHIFT];
   assign pos       = signed'({1'b0, quot});

   // truncate toward zero: scale the magnitude, restore the sign after
   always_comb begin
      if (!c5_ff.active) begin
         out_sample_in = '0;
      end else if (c5_ff.neg) begin
         out_sample_in = -pos;
      end else begin
         out_sample_in = pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_ff         <= '0;
         c5_ff         <= '0;
         out_valid_ff  <= 1'b0;
         out_active_ff <= 1'b0;
         out_last_ff   <= 1'b0;
      end else if (advance) begin
         c4_ff         <= s3_ctrl;
         c5_ff         <= c4_ff;
         out_valid_ff  <= c5_ff.valid;
         out_active_ff <= c5_ff.active;
         out_last_ff   <= c5_ff.active && c5_ff.last_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff       <= prod_in;
         out_sample_ff <= out_sample_in;
      end
   end

endmodule

FILE: rtl/sine_test_tone_generator_top.sv
// Top level of the sine test tone generator: ports, configuration, input register.
// Depends on stt_pkg, stt_setup, stt_phase, stt_sine_rom and stt_scale.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------------
//   req      | in        | req_valid/req_stall  | opcode, frequency_hz, duration_ms
//   rsp      | out       | rsp_valid/rsp_stall  | left/right_sample, tone_active, final_frame
//   csr      | in        | csr_write_en         | csr_index, csr_wdata (volume, enable)
//
// One item enters per cycle while no result is held. A tick item's frame passes, in order,
// through the input register, two stages of start arithmetic (phase step and frame count
// by reciprocal multiplies), the state stage that owns phase and frame count, the sine ROM
// read, the volume multiply, and the divide-by-100 into the result register.
// Start items travel the same pipe, so state updates stay in item order; they give no
// result. Reset (synchronous) clears the tone state, sets volume to 100 and disables starts.
// A held result stalls the whole pipe: req_stall is high while rsp_valid and rsp_stall are.
module sine_test_tone_generator_top import stt_pkg::*; #(
   parameter int unsigned FRAME_RATE   = FRAME_RATE_DEF,
   parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request items
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [FIELD_W-1:0]         req_frequency_hz,
   input  logic [FIELD_W-1:0]         req_duration_ms,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_left_sample,
   output logic signed [SAMPLE_W-1:0] rsp_right_sample,
   output logic                       rsp_tone_active,
   output logic                       rsp_final_frame,
   // configuration writes
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [VOL_W-1:0]           csr_wdata
);

   localparam int unsigned ADDR_W = $clog2(SINE_ENTRIES / 4 + 1);

   logic                       advance;
   logic [VOL_W-1:0]           vol_ff;
   logic                       enable_ff;
   logic                       s0_valid_ff, s0_opcode_ff;
   logic [FIELD_W-1:0]         s0_freq_ff, s0_dur_ff;
   setup_type                  s2;
   ctrl_type                   s3_ctrl;
   logic [ADDR_W-1:0]          s3_addr;
   logic [AMP_W-1:0]           rom_data;
   logic                       out_valid;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic                       out_active, out_last;

   // Advance every stage together unless a finished frame is held at the output.
   assign advance   = !(out_valid && rsp_stall);
   assign req_stall = !advance;

   // Configuration: clamp volume to 100 on write.
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff    <= VOL_RESET;
         enable_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_VOLUME: vol_ff    <= (csr_wdata > VOL_MAX) ? VOL_MAX : csr_wdata;
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            default:    vol_ff    <= vol_ff;
         endcase
      end
   end

   // Input register: capture the item on acceptance, drop a bubble otherwise.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_opcode_ff <= req_opcode;
         s0_freq_ff   <= req_frequency_hz;
         s0_dur_ff    <= req_duration_ms;
      end
   end

   stt_setup #(
      .FRAME_RATE (FRAME_RATE)
   ) u_setup (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (s0_valid_ff),
      .in_opcode     (s0_opcode_ff),
      .in_freq       (s0_freq_ff),
      .in_dur        (s0_dur_ff),
      .output_enable (enable_ff),
      .s2_ff         (s2)
   );

   stt_phase #(
      .SINE_ENTRIES (SINE_ENTRIES),
      .ADDR_W       (ADDR_W)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .s2         (s2),
      .s3_ctrl_ff (s3_ctrl),
      .s3_addr_ff (s3_addr)
   );

   stt_sine_rom #(
      .SINE_ENTRIES (SINE_ENTRIES),
      .ADDR_W       (ADDR_W)
   ) u_rom (
      .clock      (clock),
      .advance    (advance),
      .addr       (s3_addr),
      .rd_data_ff (rom_data)
   );

   stt_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .s3_ctrl       (s3_ctrl),
      .mag           (rom_data),
      .volume        (vol_ff),
      .out_valid_ff  (out_valid),
      .out_sample_ff (out_sample),
      .out_active_ff (out_active),
      .out_last_ff   (out_last)
   );

   // Same sample on both channels.
   assign rsp_valid        = out_valid;
   assign rsp_left_sample  = out_sample;
   assign rsp_right_sample = out_sample;
   assign rsp_tone_active  = out_active;
   assign rsp_final_frame  = out_last;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sine test tone generator: directed and random items.
// Depends on stt_pkg and sine_test_tone_generator_top; carries its own tone predictor.
module testbench import stt_pkg::*;;

   localparam int unsigned     RATE_HZ     = 16000;
   localparam int unsigned     LUT_SIZE    = 1024;
   localparam longint unsigned PI_Q31_TB   = 64'd6746518852;
   localparam int unsigned     PIPE_SETTLE = 12;
   localparam int unsigned     PHASE_ITEMS = 175;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       active;
      logic                       last;
   } frame_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_opcode = OP_TICK;
   logic [FIELD_W-1:0]         req_frequency_hz = '0;
   logic [FIELD_W-1:0]         req_duration_ms = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_sample;
   logic signed [SAMPLE_W-1:0] rsp_right_sample;
   logic                       rsp_tone_active;
   logic                       rsp_final_frame;
   logic                       csr_write_en = 1'b0;
   logic                       csr_index = CSR_VOLUME;
   logic [VOL_W-1:0]           csr_wdata = '0;

   // tone state mirrored by the predictor
   logic [VOL_W-1:0]    gain_pct = 7'd100;
   logic                tones_on = 1'b0;
   logic [31:0]         phase_acc = '0;
   logic [31:0]         phase_step = '0;
   logic [19:0]         frames_left = '0;
   int                  sine_lut [LUT_SIZE];

   frame_type           frames_due [$];
   frame_type           want;
   logic                field_bad;
   int                  mismatches = 0;
   int                  items_sent = 0;
   int                  gap_odds = 0;    // 0: sender never idles, else 1 in gap_odds
   int                  stall_odds = 0;  // 0: receiver never stalls, else 1 in stall_odds

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sine_test_tone_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_frequency_hz (req_frequency_hz),
      .req_duration_ms  (req_duration_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .rsp_tone_active  (rsp_tone_active),
      .rsp_final_frame  (rsp_final_frame),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 10000 * sin(num/den * pi/2), Q31 Taylor series, magnitude rounded toward zero
   function automatic int quarter_wave(longint unsigned num, longint unsigned den);
      longint unsigned ang;
      longint unsigned sq;
      longint unsigned t;
      longint unsigned mag;
      longint          acc;
      int              n;
      if (num == 0) begin
         return 0;
      end
      if (num >= den) begin
         return 10000;
      end
      if (3 * num == den) begin
         return 5000;
      end
      ang = (num * PI_Q31_TB) / (2 * den);
      sq  = (ang * ang) >> 31;
      t   = ang;
      acc = longint'(ang);
      for (n = 1; n < 20 && t != 0; n++) begin
         t = ((t * sq) >> 31) / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            acc = acc - longint'(t);
         end else begin
            acc = acc + longint'(t);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      mag = acc;
      return int'((mag * 10000) >> 31);
   endfunction

   // Advance the mirrored tone state by one accepted item; queue the frame a tick yields.
   function automatic void predict_item(logic op, logic [FIELD_W-1:0] f,
                                        logic [FIELD_W-1:0] d);
      frame_type   fr;
      int          scaled;
      logic [63:0] wide;
      if (op == OP_START) begin
         // drop starts while disabled or with a zero field; a running tone survives them
         if (tones_on && f != '0 && d != '0) begin
            wide        = {16'd0, f, 32'd0};
            wide        = wide / RATE_HZ;
            phase_step  = wide[31:0];
            wide        = 64'(d) * RATE_HZ / 1000;
            frames_left = (wide > 64'hFFFFF) ? 20'hFFFFF : wide[19:0];
            phase_acc   = '0;
         end
         return;
      end
      if (frames_left == '0) begin
         fr = '0;
      end else begin
         // top ten phase bits select one of the 1024 table entries
         scaled    = sine_lut[phase_acc[31 -: 10]] * int'(gain_pct) / 100;
         fr.left   = scaled[SAMPLE_W-1:0];
         fr.right  = scaled[SAMPLE_W-1:0];
         fr.active = 1'b1;
         fr.last   = (frames_left == 20'd1);
         frames_left = frames_left - 20'd1;
         phase_acc   = phase_acc + phase_step;
      end
      frames_due.push_back(fr);
   endfunction

   // Present one item and hold it until accepted; valid stays high for a following item.
   task automatic send_item(logic op, logic [FIELD_W-1:0] f, logic [FIELD_W-1:0] d);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_frequency_hz <= f;
      req_duration_ms  <= d;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_item(op, f, d);
      items_sent++;
   endtask

   // Tick payload fields carry noise; the block must ignore them.
   task automatic send_tick();
      send_item(OP_TICK, 16'($urandom), 16'($urandom));
   endtask

   // Drop valid, wait for every queued frame, then let any trailing start leave the pipe.
   task automatic settle_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [VOL_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_VOLUME) begin
         gain_pct = (data > VOL_MAX) ? VOL_MAX : data;
      end else begin
         tones_on = data[0];
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Reset state: idle frames are zero and starts are dropped while output is disabled.
   task automatic test_idle_after_reset();
      send_tick();
      send_item(OP_START, 16'd1000, 16'd10);
      send_tick();
      settle_pipe();
   endtask

   // A 4000 Hz step is a quarter turn, so frames walk 0, +peak, 0, -peak at reset volume.
   // Zero-field starts arrive mid-tone and must not disturb it; run past the final frame.
   task automatic test_tone_lifecycle();
      write_reg(CSR_ENABLE, 7'd1);
      send_item(OP_START, 16'd4000, 16'd1);
      repeat (2) send_tick();
      send_item(OP_START, 16'd0, 16'd9);
      send_item(OP_START, 16'd123, 16'd0);
      repeat (15) send_tick();
      settle_pipe();
   endtask

   // Widest fields: the phase step aliases and the frame count peaks; then the smallest tone.
   task automatic test_field_extremes();
      send_item(OP_START, 16'hFFFF, 16'hFFFF);
      repeat (2) send_tick();
      send_item(OP_START, 16'd1, 16'd1);
      send_tick();
      settle_pipe();
   endtask

   // One setting of both registers, then mostly complete short tones with random content,
   // some long tones cut off by the next start, and some dropped starts and stray ticks.
   task automatic test_random_tones(logic [VOL_W-1:0] vol, logic en, int odds);
      int                 first;
      int                 ticks;
      int                 frames;
      logic [FIELD_W-1:0] f;
      logic [FIELD_W-1:0] d;
      int                 pick;
      write_reg(CSR_VOLUME, vol);
      write_reg(CSR_ENABLE, {6'($urandom), en});
      gap_odds   = odds;
      stall_odds = odds;
      first      = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            case ($urandom_range(0, 3))
               0: begin
                  f = 16'($urandom_range(20, 4000));
               end
               1: begin
                  f = 16'($urandom_range(4001, 65535));
               end
               2: begin
                  f = 16'($urandom_range(1, 4) * 4000);  // whole fractions of a turn
               end
               default: begin
                  f = 16'($urandom_range(1, 65535));
               end
            endcase
            d      = 16'($urandom_range(1, 3));
            frames = d * RATE_HZ / 1000;
            send_item(OP_START, f, d);
            // usually play to the end and a bit past it, sometimes stop early
            if ($urandom_range(0, 3) == 0) begin
               ticks = $urandom_range(1, frames);
            end else begin
               ticks = frames + $urandom_range(0, 2);
            end
         end else if (pick < 9) begin
            send_item(OP_START, 16'($urandom), 16'($urandom));
            ticks = $urandom_range(0, 12);
         end else begin
            f = 16'($urandom);
            d = 16'($urandom);
            case ($urandom_range(0, 2))
               0: begin
                  f = '0;
               end
               1: begin
                  d = '0;
               end
               default: begin
                  f = '0;
                  d = '0;
               end
            endcase
            send_item(OP_START, f, d);
            ticks = $urandom_range(0, 4);
         end
         repeat (ticks) send_tick();
      end
      settle_pipe();
      gap_odds   = 0;
      stall_odds = 0;
   endtask

   // Receiver: stall in random bursts while stall_odds allows it.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted frame against the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected frame: left %0d right %0d active %0b final %0b",
                        rsp_left_sample, rsp_right_sample, rsp_tone_active,
                        rsp_final_frame);
            end
         end else begin
            want      = frames_due.pop_front();
            field_bad = (rsp_left_sample !== want.left) || (rsp_right_sample !== want.right)
                        || (rsp_tone_active !== want.active)
                        || (rsp_final_frame !== want.last);
            if (field_bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("frame mismatch at %0t: left %0d/%0d right %0d/%0d active %0b/%0b final %0b/%0b (expected/actual)",
                           $realtime, want.left, rsp_left_sample, want.right,
                           rsp_right_sample, want.active, rsp_tone_active, want.last,
                           rsp_final_frame);
               end
            end
         end
      end
   end

   // Hard limit on the run, far beyond the slowest legal schedule.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int a;
      int i;
      int quad;
      int r;
      // build the sine table by quadrant symmetry
      for (i = 0; i < LUT_SIZE; i++) begin
         a    = i * 4;
         quad = (a / LUT_SIZE) % 4;
         r    = a % LUT_SIZE;
         case (quad)
            0: begin
               sine_lut[i] = quarter_wave(r, LUT_SIZE);
            end
            1: begin
               sine_lut[i] = quarter_wave(LUT_SIZE - r, LUT_SIZE);
            end
            2: begin
               sine_lut[i] = -quarter_wave(r, LUT_SIZE);
            end
            default: begin
               sine_lut[i] = -quarter_wave(LUT_SIZE - r, LUT_SIZE);
            end
         endcase
      end
      // hold reset, then release it for good
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_after_reset();
      test_tone_lifecycle();
      test_field_extremes();

      // sweep gain extremes and enable; the last phase runs with no idling on either side
      test_random_tones(7'd0, 1'b1, 4);
      test_random_tones(7'd127, 1'b1, 6);
      test_random_tones(7'd1, 1'b1, 3);
      test_random_tones(7'd101, 1'b0, 5);
      test_random_tones(7'($urandom), 1'b1, 8);
      test_random_tones(7'($urandom_range(0, 100)), 1'b1, 2);
      test_random_tones(7'd100, 1'b1, 5);
      test_random_tones(7'($urandom), 1'b1, 0);

      settle_pipe();
      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
